// File: rtl/hmsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hmsc_pkg;

  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CNT_W-1:0] SEC_LIMIT  = 8'd60;
  localparam logic [CNT_W-1:0] MIN_LIMIT  = 8'd60;
  localparam logic [CNT_W-1:0] HOUR_LIMIT = 8'd24;

  // frame positions
  localparam logic [IDX_W-1:0] IDX_SEC_TENS   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_SEC_UNITS  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_BLANK_A    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_BLANK_B    = 3'd3;
  localparam logic [IDX_W-1:0] IDX_MIN_TENS   = 3'd4;
  localparam logic [IDX_W-1:0] IDX_MIN_UNITS  = 3'd5;
  localparam logic [IDX_W-1:0] IDX_HOUR_TENS  = 3'd6;
  localparam logic [IDX_W-1:0] IDX_HOUR_UNITS = 3'd7;
  localparam logic [IDX_W-1:0] IDX_LAST       = IDX_HOUR_UNITS;

  localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'h00;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  function automatic logic [BYTE_W-1:0] seg_of(input logic [3:0] digit);
    logic [BYTE_W-1:0] pat;
    case (digit)
      4'd0:    pat = 8'b0111_0111;
      4'd1:    pat = 8'b0010_0100;
      4'd2:    pat = 8'b0110_1011;
      4'd3:    pat = 8'b0110_1101;
      4'd4:    pat = 8'b0011_1100;
      4'd5:    pat = 8'b0101_1101;
      4'd6:    pat = 8'b0101_1111;
      4'd7:    pat = 8'b0110_0100;
      4'd8:    pat = 8'b0111_1111;
      4'd9:    pat = 8'b0111_1100;
      default: pat = BLANK_BYTE;
    endcase
    return pat;
  endfunction

  // divide by ten via multiply by 13 and shift, exact for 0..63
  function automatic digits_t split_digits(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] rem;
    digits_t    d;
    prod    = 10'(v) * 10'd13;
    tens    = prod[9:7];
    rem     = v - 6'(6'(tens) * 6'd10);
    d.tens  = {1'b0, tens};
    d.units = rem[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hms_clock_seven_segment_frame.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   tick, key flags, refresh
// out_      output     out_valid/out_stall display_byte, byte_index, last
//
// an item without refresh only updates the time; the update is done in the
// accept cycle and lands in the count registers.
// an item with refresh also sends a frame from a snapshot register, one byte
// a cycle while out_stall is low; the next item is taken with the last byte.
// rst_n clears the time to 00:00:00 and drops out_valid.
// out_stall holds the current byte and, on the final byte, holds off input.

module hms_clock_seven_segment_frame (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_tick,
  input  wire logic                        in_hour_down,
  input  wire logic                        in_minute_up,
  input  wire logic                        in_minute_down,
  input  wire logic                        in_second_up,
  input  wire logic                        in_hour_up,
  input  wire logic                        in_clear_time,
  input  wire logic                        in_refresh,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [hmsc_pkg::BYTE_W-1:0] out_display_byte,
  output      logic [hmsc_pkg::IDX_W-1:0]  out_byte_index,
  output      logic                        out_last
);
  import hmsc_pkg::*;

  logic [SEC_W-1:0]  sec_r,  sec_nxt;
  logic [MIN_W-1:0]  min_r,  min_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;

  logic [SEC_W-1:0]  snap_sec_r;
  logic [MIN_W-1:0]  snap_min_r;
  logic [HOUR_W-1:0] snap_hour_r;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r,  idx_nxt;

  logic in_take, out_take, frame_done;

  logic [CNT_W-1:0] s8, m8, h8, m9, h9;
  logic             s_carry, m_carry;

  digits_t           dig;
  logic [SEC_W-1:0]  dig_src;
  logic [BYTE_W-1:0] units_seg;

  assign out_take   = busy_r && !out_stall;
  assign frame_done = out_take && (idx_r == IDX_LAST);
  assign in_stall   = busy_r && !frame_done;
  assign in_take    = in_valid && !in_stall;

  // time update, eight-bit wrapping counts then normalise
  always_comb begin
    s8 = CNT_W'(sec_r) + CNT_W'(in_tick) + CNT_W'(in_second_up);
    m8 = CNT_W'(min_r) + CNT_W'(in_minute_up) - CNT_W'(in_minute_down);
    h8 = CNT_W'(hour_r) - CNT_W'(in_hour_down) + CNT_W'(in_hour_up);
    if (in_clear_time) begin
      s8 = '0;
      m8 = '0;
      h8 = '0;
    end
    s_carry = (s8 >= SEC_LIMIT);
    m9      = m8 + CNT_W'(s_carry);
    m_carry = (m9 >= MIN_LIMIT);
    h9      = h8 + CNT_W'(m_carry);
    sec_nxt  = s_carry ? '0 : s8[SEC_W-1:0];
    min_nxt  = m_carry ? '0 : m9[MIN_W-1:0];
    hour_nxt = (h9 >= HOUR_LIMIT) ? '0 : h9[HOUR_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (out_take) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (idx_r == IDX_LAST) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_take && in_refresh) begin
      busy_nxt = 1'b1;
      idx_nxt  = IDX_SEC_TENS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      busy_r <= 1'b0;
      idx_r  <= IDX_SEC_TENS;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (in_take) begin
        sec_r  <= sec_nxt;
        min_r  <= min_nxt;
        hour_r <= hour_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_refresh) begin
      snap_sec_r  <= sec_nxt;
      snap_min_r  <= min_nxt;
      snap_hour_r <= hour_nxt;
    end
  end

  // frame byte from the snapshot
  always_comb begin
    case (idx_r)
      IDX_SEC_TENS, IDX_SEC_UNITS:   dig_src = snap_sec_r;
      IDX_MIN_TENS, IDX_MIN_UNITS:   dig_src = snap_min_r;
      IDX_HOUR_TENS, IDX_HOUR_UNITS: dig_src = SEC_W'(snap_hour_r);
      default:                       dig_src = '0;
    endcase
    dig = split_digits(dig_src);
  end

  assign units_seg = seg_of(dig.units);

  always_comb begin
    case (idx_r)
      IDX_SEC_TENS, IDX_MIN_TENS, IDX_HOUR_TENS: begin
        out_display_byte = seg_of(dig.tens);
      end
      IDX_SEC_UNITS, IDX_MIN_UNITS, IDX_HOUR_UNITS: begin
        out_display_byte = {units_seg[BYTE_W-2:0], 1'b0};
      end
      IDX_BLANK_A, IDX_BLANK_B: out_display_byte = BLANK_BYTE;
      default:                  out_display_byte = BLANK_BYTE;
    endcase
  end

  assign out_valid      = busy_r;
  assign out_byte_index = idx_r;
  assign out_last       = (idx_r == IDX_LAST);

  a_accept_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && in_valid && !in_stall) |-> (!out_stall && idx_r == IDX_LAST))
    else $error("input taken in the middle of a frame");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(sec_r) < SEC_LIMIT) && (CNT_W'(min_r) < MIN_LIMIT)
      && (CNT_W'(hour_r) < HOUR_LIMIT))
    else $error("time count out of range");

  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_refresh) |=> (out_valid && idx_r == IDX_SEC_TENS))
    else $error("refresh did not start a frame");

  a_frame_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && idx_r != IDX_LAST)
      |=> (out_valid && idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("frame byte skipped or repeated");

  a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && idx_r == IDX_LAST && !(in_valid && in_refresh))
      |=> !out_valid)
    else $error("output valid without a pending frame");

endmodule

`default_nettype wire
